// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared AES-128 types, S-box and round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic   last;
        block_t key;
    } round_ctl_t;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input block_t b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] gmul2(input logic [7:0] v);
        gmul2 = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the current one
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

    // SubBytes and ShiftRows; byte index is 4*col + row
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[get_byte(s, 4 * ((c + r) % 4) + r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic block_t mix(input block_t s);
        block_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 32] = {a0 ^ all ^ gmul2(a0 ^ a1), a1 ^ all ^ gmul2(a1 ^ a2),
                                     a2 ^ all ^ gmul2(a2 ^ a3), a3 ^ all ^ gmul2(a3 ^ a0)};
        end
        mix = t;
    endfunction

endpackage

// ===== design/aes_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// One registered cipher round with its own key expansion step.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
#(
    parameter logic [7:0] RC = 8'h01
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  block_t     in_state,
    input  round_ctl_t in_ctl,
    output logic       out_valid,
    output block_t     out_state,
    output block_t     out_key
);

    block_t key_next;
    block_t state_next;
    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;

    always_comb
    begin
        key_next   = next_key(in_ctl.key, RC);
        state_next = in_ctl.last ? sub_shift(in_state) : mix(sub_shift(in_state));
        state_next = state_next ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

// ===== design/aes128_block_encrypt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// Fully pipelined AES-128 encryption, one block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index (0 = key_high,
//   1 = key_low) and cfg_data. Other indexes are ignored. Write the key
//   only while the pipeline is empty.
//   s_axis: plaintext transfer, tdata = {plain_low, plain_high} with
//   plain_high in the low 64 bits.
//   m_axis: ciphertext transfer, same packing.
// Pipeline: 11 register stages (one for the initial AddRoundKey, then one
//   per round; each round stage holds one S-box layer plus its key
//   expansion step). m_axis_tvalid rises once a block leaves the last
//   round stage, and the result transfers when m_axis_tready is high.
// Throughput: one block per cycle while m_axis_tready is high.
// Reset: pipeline valids clear, key registers clear to zero.
// Stall: when m_axis_tready is low with a valid result the whole pipeline
//   freezes and s_axis_tready drops with it, even if earlier stages only
//   hold bubbles.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_core
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] plain_high, [127:64] plain_low
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] cipher_high, [127:64] cipher_low
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        en;

    logic   v    [NUM_ROUNDS + 1];
    block_t st   [NUM_ROUNDS + 1];
    block_t ky   [NUM_ROUNDS + 1];
    logic   v0_reg;
    block_t st0_reg;
    block_t ky0_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the result is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    // initial AddRoundKey; block byte 0 sits in the top bits of the state
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st0_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                       ^ {key_high_reg, key_low_reg};
            ky0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign v[0]  = v0_reg;
    assign st[0] = st0_reg;
    assign ky[0] = ky0_reg;

    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        round_ctl_t ctl;
        assign ctl.last = (r == NUM_ROUNDS - 1);
        assign ctl.key  = ky[r];
        aes_round #(.RC(RCON[r])) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[r]),
            .in_state  (st[r]),
            .in_ctl    (ctl),
            .out_valid (v[r + 1]),
            .out_state (st[r + 1]),
            .out_key   (ky[r + 1])
        );
    end

    assign m_axis_tvalid = v[NUM_ROUNDS];
    assign m_axis_tdata  = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};

endmodule

// ===== design/aes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker
// Port-level assertions for the AES-128 core, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // input ready follows the output side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready mismatch");

    // handshake outputs always known once out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({m_axis_tvalid, s_axis_tready}))
        else $error("unknown handshake output");

endmodule

bind aes128_block_encrypt_core aes_checker u_aes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_aes128_block_encrypt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_core
// Self-checking bench for the AES-128 encrypt pipeline: random and directed
// plaintext blocks under several keys, each ciphertext checked against an
// in-bench AES-128 encryptor, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_core;
    import aes_pkg::*;

    localparam int PIPE_DEPTH     = 11;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BLOCKS  = 1700;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;     // [63:0] plain_high, [127:64] plain_low
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;     // [63:0] cipher_high, [127:64] cipher_low

    // Sbox copied from the package into a bench-local table
    logic [7:0] sbox_tbl [256];
    logic [7:0] rcon_tbl [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                  8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    // Key as the bench believes it is loaded
    logic [63:0] key_hi_model;
    logic [63:0] key_lo_model;

    // blocks kept as {high, low}, byte 0 in the top bits
    logic [127:0] plain_pending [$];   // blocks waiting for the driver
    logic [127:0] cipher_expected [$]; // ciphertexts in flight

    int  error_count;
    int  idle_cycles;
    bit  stalls_on;       // random idling enabled
    bit  hold_sender;     // sender paused by the sequencer
    int  sink_hold;       // long receiver hold-off, counted by the monitor
    int  src_gap;
    int  sink_gap;

    aes128_block_encrypt_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // GF(2^8) doubling
    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Full AES-128 encryption; state byte n is st[n], n = 4*col + row
    function automatic logic [127:0] cipher_model(input logic [127:0] key,
                                                  input logic [127:0] plain);
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  rk [16];
        logic [7:0]  a0, a1, a2, a3, all, s0;
        logic [127:0] res;
        for (int n = 0; n < 16; n++)
        begin
            rk[n] = key[127 - 8 * n -: 8];
            st[n] = plain[127 - 8 * n -: 8] ^ rk[n];
        end
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            // next round key
            s0 = rk[12];
            rk[0] = rk[0] ^ sbox_tbl[rk[13]] ^ rcon_tbl[rnd - 1];
            rk[1] = rk[1] ^ sbox_tbl[rk[14]];
            rk[2] = rk[2] ^ sbox_tbl[rk[15]];
            rk[3] = rk[3] ^ sbox_tbl[s0];
            for (int n = 4; n < 16; n++)
                rk[n] = rk[n] ^ rk[n - 4];
            // SubBytes + ShiftRows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4 * c + r] = sbox_tbl[st[4 * ((c + r) % 4) + r]];
            st = tmp;
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c];     a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++)
                st[n] = st[n] ^ rk[n];
        end
        for (int n = 0; n < 16; n++)
            res[127 - 8 * n -: 8] = st[n];
        cipher_model = res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    function automatic logic [63:0] rand64();
        rand64 = {$urandom, $urandom};
    endfunction

    // Plaintext mix: mostly random, some sparse/dense bit patterns
    function automatic logic [127:0] pick_plain();
        logic [127:0] p;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            2: p = 128'd1 << $urandom_range(0, 127);
            3: p = ~(128'd1 << $urandom_range(0, 127));
            default: p = {rand64(), rand64()};
        endcase
        pick_plain = p;
    endfunction

    // Key register write; only called with the pipeline drained
    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_HIGH)
            key_hi_model = val;
        else if (idx == CFG_KEY_LOW)
            key_lo_model = val;
    endtask

    task automatic drain();
        wait (plain_pending.size() == 0 && !s_axis_tvalid && cipher_expected.size() == 0);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // Driver: one transfer per handshake, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] blk;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                cipher_expected.push_back(cipher_model({key_hi_model, key_lo_model},
                                          {s_axis_tdata[63:0], s_axis_tdata[127:64]}));
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;   // hold the offered block
            else if (src_gap > 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (plain_pending.size() > 0 && !hold_sender)
            begin
                blk = plain_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {blk[63:0], blk[127:64]};
                if (stalls_on && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 12);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each output transfer, drives tready with stalls
    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
            idle_cycles   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    report_mismatch("unexpected cipher_high", m_axis_tdata[63:0], 64'h0);
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (m_axis_tdata[63:0] !== want[127:64])
                        report_mismatch("cipher_high", m_axis_tdata[63:0], want[127:64]);
                    if (m_axis_tdata[127:64] !== want[63:0])
                        report_mismatch("cipher_low", m_axis_tdata[127:64], want[63:0]);
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (sink_hold > 0)
            begin
                sink_hold     <= sink_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (stalls_on && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 12);
            end
        end
    end

    // Watchdog on lack of progress
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] key_set [4][2];
        sbox_tbl      = SBOX;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KEY_HIGH;
        cfg_data      = '0;
        key_hi_model  = '0;
        key_lo_model  = '0;
        error_count   = 0;
        stalls_on     = 1'b0;
        hold_sender   = 1'b0;
        sink_hold     = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset key is all zero: known-answer plus extremes
        plain_pending.push_back('0);
        plain_pending.push_back('1);
        plain_pending.push_back(128'h00112233445566778899aabbccddeeff);
        drain();

        // FIPS-197 appendix C.1 key, then all-ones key; unused index is ignored
        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_key(2'd2, rand64());
        write_key(2'd3, rand64());
        plain_pending.push_back(128'h00112233445566778899aabbccddeeff);
        plain_pending.push_back('0);
        plain_pending.push_back(128'h1);
        plain_pending.push_back(128'h8000_0000_0000_0000_0000_0000_0000_0000);
        drain();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        plain_pending.push_back('0);
        plain_pending.push_back('1);
        plain_pending.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
        plain_pending.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
        drain();

        // Random phases under several keys, idling on
        key_set[0] = '{'0, '1};
        key_set[1] = '{'1, '0};
        key_set[2] = '{rand64(), rand64()};
        key_set[3] = '{rand64(), rand64()};
        stalls_on = 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_key(CFG_KEY_HIGH, key_set[ph][0]);
            write_key(CFG_KEY_LOW, key_set[ph][1]);
            if (ph == 1)
            begin
                // Long receiver hold-off while the sender keeps offering
                sink_hold <= 60;
            end
            for (int n = 0; n < RANDOM_BLOCKS / 5; n++)
                plain_pending.push_back(pick_plain());
            if (ph == 2)
            begin
                // Sender pauses midway until all ciphertexts are back
                wait (plain_pending.size() < RANDOM_BLOCKS / 10);
                hold_sender = 1'b1;
                wait (cipher_expected.size() == 0 && !s_axis_tvalid);
                hold_sender = 1'b0;
            end
            drain();
        end

        // Final stretch at full rate
        stalls_on = 1'b0;
        write_key(CFG_KEY_HIGH, rand64());
        write_key(CFG_KEY_LOW, rand64());
        for (int n = 0; n < RANDOM_BLOCKS / 5; n++)
            plain_pending.push_back(pick_plain());
        drain();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/aes_pkg.sv
design/aes_round.sv
design/aes128_block_encrypt_core.sv
design/aes_checker.sv
tb/tb_aes128_block_encrypt_core.sv
